// ===== hw/rtl/acss_pkg.sv =====
package acss_pkg;

   // Fixed field widths of the scan interface.
   localparam int CHAN_BITS   = 4;
   localparam int COUNT_BITS  = 5;
   localparam int SETTLE_BITS = 8;
   localparam int CODE_BITS   = 24;
   localparam int POLL_BITS   = 9;
   localparam int CSR_DATA_BITS = 8;

   // Channel wrap limit and the significant width of a converter code.
   localparam int MAX_CHANNELS = 16;
   localparam int CODE_WIDTH   = 24;

   // Width used to compare a channel against the wrap limit.
   localparam int WRAP_BITS = 7;

   // Missed polls allowed before the converters are reinitialized.
   localparam logic [POLL_BITS-1:0] POLL_LIMIT = 9'h0FF;
   localparam logic [POLL_BITS-1:0] POLL_MAX   = 9'h1FF;

   // Reset values of the configuration registers.
   localparam logic [COUNT_BITS-1:0]  CHANNEL_COUNT_RESET = 5'd8;
   localparam logic [SETTLE_BITS-1:0] SETTLE_TICKS_RESET  = 8'd4;

   // Bits of a code that take part in the zero test.
   localparam logic [CODE_BITS-1:0] CODE_MASK = (CODE_WIDTH >= CODE_BITS) ? '1 :
      CODE_BITS'((64'd1 << CODE_WIDTH) - 64'd1);

   typedef enum logic [1:0] {
      ACT_TICK    = 2'd0,
      ACT_SELECT  = 2'd1,
      ACT_TRIGGER = 2'd2,
      ACT_RESTORE = 2'd3
   } action_type;

   typedef enum logic [0:0] {
      CSR_CHANNEL_COUNT = 1'b0,
      CSR_SETTLE_TICKS  = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_OPEN    = 3'd1,
      PH_SETTLE  = 3'd2,
      PH_TRIGGER = 3'd3,
      PH_READ_I  = 3'd4,
      PH_READ_V  = 3'd5,
      PH_CLOSE   = 3'd6,
      PH_PARKED  = 3'd7
   } phase_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0]  channel_count;
      logic [SETTLE_BITS-1:0] settle_ticks;
   } cfg_type;

   typedef struct packed {
      action_type           action;
      logic [CHAN_BITS-1:0] special_channel;
      logic                 current_ready;
      logic                 voltage_ready;
      logic [CODE_BITS-1:0] adc_code;
   } item_type;

   typedef struct packed {
      phase_type              phase;
      logic [SETTLE_BITS-1:0] settle_count;
      logic [CHAN_BITS-1:0]   scan_channel;
      logic [CHAN_BITS-1:0]   pinned_channel;
      logic [CHAN_BITS-1:0]   saved_channel;
      logic                   special_mode;
      logic                   switched_to_pinned;
      logic                   parked_ready;
      logic [POLL_BITS-1:0]   poll_count;
   } state_type;

   typedef struct packed {
      logic                 mux_open;
      logic [CHAN_BITS-1:0] mux_channel;
      logic                 start_convert;
      logic                 current_store;
      logic                 voltage_store;
      logic [CHAN_BITS-1:0] sample_channel;
      logic [CODE_BITS-1:0] sample_code;
      logic                 reinit_request;
      phase_type            phase;
   } result_type;

endpackage

// ===== hw/rtl/adc_channel_scan_sequencer.sv =====
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_ready   action, special channel, ready flags, code
// rsp       out        rsp_valid/rsp_ready   mux, conversion, store, reinit and phase fields
// csr       in         csr_valid/csr_ready   register index, write data
//
// A transaction is held in the input register, and then its result in the result register.
// One transaction is accepted every cycle unless the input register is full behind a stalled result.
// Reset is synchronous and active high; it returns the sequencer to idle on channel 0.
// A stalled result holds the result register, and the input register fills behind it.
// Configuration writes are always taken.
module adc_channel_scan_sequencer (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  acss_pkg::action_type                    req_action,
   input  logic [acss_pkg::CHAN_BITS-1:0]          req_special_channel,
   input  logic                                    req_current_ready,
   input  logic                                    req_voltage_ready,
   input  logic [acss_pkg::CODE_BITS-1:0]          req_adc_code,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic                                    rsp_mux_open,
   output logic [acss_pkg::CHAN_BITS-1:0]          rsp_mux_channel,
   output logic                                    rsp_start_convert,
   output logic                                    rsp_current_store,
   output logic                                    rsp_voltage_store,
   output logic [acss_pkg::CHAN_BITS-1:0]          rsp_sample_channel,
   output logic [acss_pkg::CODE_BITS-1:0]          rsp_sample_code,
   output logic                                    rsp_reinit_request,
   output logic [2:0]                              rsp_phase,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  acss_pkg::csr_index_type                 csr_index,
   input  logic [acss_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);
   import acss_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   item_type   item_ff, item_in;
   logic       item_valid_ff, item_valid_in;
   state_type  state_ff, state_in;
   result_type rsp_ff, rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;
   state_type  step_state;
   result_type step_result;
   logic       advance;

   // The held transaction moves on when the result register is free or being emptied.
   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;
   assign csr_ready = 1'b1;

   // Configuration writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CHANNEL_COUNT: cfg_in.channel_count = csr_wdata[COUNT_BITS-1:0];
            CSR_SETTLE_TICKS:  cfg_in.settle_ticks  = csr_wdata[SETTLE_BITS-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   // Input register capture.
   always_comb begin
      item_in       = item_ff;
      item_valid_in = item_valid_ff && !advance;
      if (req_valid && req_ready) begin
         item_in.action          = req_action;
         item_in.special_channel = req_special_channel;
         item_in.current_ready   = req_current_ready;
         item_in.voltage_ready   = req_voltage_ready;
         item_in.adc_code        = req_adc_code;
         item_valid_in           = 1'b1;
      end
   end

   acss_step u_step (
      .cfg       (cfg_ff),
      .state     (state_ff),
      .item      (item_ff),
      .state_nxt (step_state),
      .result    (step_result)
   );

   // Sequencer state and result register update.
   assign state_in     = advance ? step_state : state_ff;
   assign rsp_in       = advance ? step_result : rsp_ff;
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel_count <= CHANNEL_COUNT_RESET;
         cfg_ff.settle_ticks  <= SETTLE_TICKS_RESET;
         item_valid_ff        <= 1'b0;
         rsp_valid_ff         <= 1'b0;
         state_ff             <= '0;
      end else begin
         cfg_ff        <= cfg_in;
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         state_ff      <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   // Result ports.
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_mux_open       = rsp_ff.mux_open;
   assign rsp_mux_channel    = rsp_ff.mux_channel;
   assign rsp_start_convert  = rsp_ff.start_convert;
   assign rsp_current_store  = rsp_ff.current_store;
   assign rsp_voltage_store  = rsp_ff.voltage_store;
   assign rsp_sample_channel = rsp_ff.sample_channel;
   assign rsp_sample_code    = rsp_ff.sample_code;
   assign rsp_reinit_request = rsp_ff.reinit_request;
   assign rsp_phase          = rsp_ff.phase;

   // A parked sequencer is always in special measurement.
   parked_needs_special: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PH_PARKED) |-> state_ff.special_mode)
      else $error("parked phase without special mode");

   // The pinned channel is only in use during special measurement.
   pinned_needs_special: assert property (@(posedge clock) disable iff (reset)
      state_ff.switched_to_pinned |-> state_ff.special_mode)
      else $error("switched to pinned channel outside special mode");

   // Only one converter is read per transaction.
   one_store: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.current_store && rsp_ff.voltage_store))
      else $error("both store flags set");

   // A timeout always lands in idle on channel zero.
   reinit_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.reinit_request) |->
         (rsp_ff.phase == PH_IDLE && rsp_ff.mux_channel == '0))
      else $error("reinit without return to idle");

   // A conversion start is always followed by the current read phase.
   start_to_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.start_convert) |-> (rsp_ff.phase == PH_READ_I))
      else $error("start without current read phase");

endmodule

// ===== hw/rtl/acss_step.sv =====
module acss_step (
   input  acss_pkg::cfg_type    cfg,
   input  acss_pkg::state_type  state,
   input  acss_pkg::item_type   item,
   output acss_pkg::state_type  state_nxt,
   output acss_pkg::result_type result
);
   import acss_pkg::*;

   logic                    is_tick;
   logic                    missed_poll;
   logic                    poll_timeout;
   logic                    code_nonzero;
   logic [SETTLE_BITS-1:0]  settle_inc;
   logic                    settle_done;
   logic [COUNT_BITS-1:0]   chan_inc;
   logic                    chan_wrap;
   logic [CHAN_BITS-1:0]    chan_next;
   logic                    store;
   phase_type               phase_nxt;

   // Shared decodes for the tick phases.
   assign is_tick      = (item.action == ACT_TICK);
   assign missed_poll  = is_tick &&
                         (((state.phase == PH_READ_I) && !item.current_ready) ||
                          ((state.phase == PH_READ_V) && !item.voltage_ready));
   assign poll_timeout = missed_poll && (state.poll_count >= POLL_LIMIT);
   assign code_nonzero = ((item.adc_code & CODE_MASK) != '0);
   assign settle_inc   = state.settle_count + SETTLE_BITS'(1);
   assign settle_done  = (settle_inc >= cfg.settle_ticks);

   // Round-robin successor, wrapping at the configured count or the channel limit.
   assign chan_inc  = {1'b0, state.scan_channel} + COUNT_BITS'(1);
   assign chan_wrap = (chan_inc >= cfg.channel_count) ||
                      ({{(WRAP_BITS-COUNT_BITS){1'b0}}, chan_inc} >= WRAP_BITS'(MAX_CHANNELS));
   assign chan_next = chan_wrap ? '0 : chan_inc[CHAN_BITS-1:0];

   // Next phase.
   always_comb begin
      phase_nxt = state.phase;
      case (item.action)
         ACT_SELECT:  phase_nxt = state.phase;
         ACT_TRIGGER: phase_nxt = PH_TRIGGER;
         ACT_RESTORE: phase_nxt = PH_IDLE;
         default: begin
            case (state.phase)
               PH_IDLE:    phase_nxt = PH_OPEN;
               PH_OPEN:    phase_nxt = PH_SETTLE;
               PH_SETTLE: begin
                  if (settle_done) begin
                     phase_nxt = (state.special_mode && state.switched_to_pinned) ?
                                 PH_PARKED : PH_TRIGGER;
                  end
               end
               PH_TRIGGER: phase_nxt = PH_READ_I;
               PH_READ_I: begin
                  if (item.current_ready) begin
                     phase_nxt = PH_READ_V;
                  end else if (poll_timeout) begin
                     phase_nxt = PH_IDLE;
                  end
               end
               PH_READ_V: begin
                  if (item.voltage_ready) begin
                     phase_nxt = PH_CLOSE;
                  end else if (poll_timeout) begin
                     phase_nxt = PH_IDLE;
                  end
               end
               PH_CLOSE: begin
                  phase_nxt = (state.special_mode && state.parked_ready) ?
                              PH_PARKED : PH_OPEN;
               end
               default:    phase_nxt = PH_PARKED;
            endcase
         end
      endcase
   end

   // Remaining state and the per-transaction pulses.
   always_comb begin
      state_nxt.phase              = phase_nxt;
      state_nxt.settle_count       = state.settle_count;
      state_nxt.scan_channel       = state.scan_channel;
      state_nxt.pinned_channel     = state.pinned_channel;
      state_nxt.saved_channel      = state.saved_channel;
      state_nxt.special_mode       = state.special_mode;
      state_nxt.switched_to_pinned = state.switched_to_pinned;
      state_nxt.parked_ready       = state.parked_ready;
      state_nxt.poll_count         = state.poll_count;
      result.mux_open       = 1'b0;
      result.start_convert  = 1'b0;
      result.current_store  = 1'b0;
      result.voltage_store  = 1'b0;
      result.reinit_request = 1'b0;

      case (item.action)
         ACT_SELECT: begin
            state_nxt.pinned_channel = item.special_channel;
            state_nxt.saved_channel  = state.scan_channel;
            state_nxt.special_mode   = 1'b1;
            state_nxt.parked_ready   = 1'b0;
         end
         ACT_TRIGGER: ;
         ACT_RESTORE: begin
            state_nxt.scan_channel       = state.saved_channel;
            state_nxt.special_mode       = 1'b0;
            state_nxt.switched_to_pinned = 1'b0;
         end
         default: begin
            case (state.phase)
               PH_IDLE: begin
                  state_nxt.settle_count = '0;
                  state_nxt.scan_channel = '0;
               end
               PH_OPEN: begin
                  state_nxt.settle_count = '0;
                  result.mux_open        = 1'b1;
                  if (state.special_mode) begin
                     state_nxt.switched_to_pinned = 1'b1;
                     state_nxt.scan_channel       = state.pinned_channel;
                  end
               end
               PH_SETTLE: begin
                  state_nxt.settle_count = settle_done ? '0 : settle_inc;
               end
               PH_TRIGGER: begin
                  result.start_convert = 1'b1;
                  state_nxt.poll_count = '0;
               end
               PH_READ_I: begin
                  result.current_store = item.current_ready && code_nonzero;
               end
               PH_READ_V: begin
                  result.voltage_store = item.voltage_ready && code_nonzero;
               end
               PH_CLOSE: begin
                  if (!state.special_mode) begin
                     state_nxt.scan_channel = chan_next;
                  end else if (!state.parked_ready) begin
                     state_nxt.scan_channel = state.pinned_channel;
                  end
               end
               default: state_nxt.parked_ready = 1'b1;
            endcase

            // A missed poll counts up to saturation; the one past the allowed limit reinitializes.
            if (missed_poll) begin
               if (state.poll_count < POLL_MAX) begin
                  state_nxt.poll_count = state.poll_count + POLL_BITS'(1);
               end
               if (poll_timeout) begin
                  result.reinit_request        = 1'b1;
                  state_nxt.scan_channel       = '0;
                  state_nxt.saved_channel      = '0;
                  state_nxt.special_mode       = 1'b0;
                  state_nxt.switched_to_pinned = 1'b0;
               end
            end
         end
      endcase

      // Reported fields follow the updated state.
      store                 = result.current_store || result.voltage_store;
      result.mux_channel    = state_nxt.scan_channel;
      result.sample_channel = store ? state_nxt.scan_channel : '0;
      result.sample_code    = store ? (item.adc_code & CODE_MASK) : '0;
      result.phase          = state_nxt.phase;
   end

endmodule
